FILE: rtl/i2ct_pkg.sv
// Shared types, codes and helper functions of the I2C target block.
`timescale 1ns / 1ps

package i2ct_pkg;

   localparam int unsigned AddrWidth  = 7;
   localparam int unsigned DataWidth  = 64;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned MaxBytes   = 8;

   localparam logic [AddrWidth-1:0]  OwnAddressReset = 7'd42;
   localparam logic [DataWidth-1:0]  TxDataReset     = 64'h1122_3344_5566_7788;
   localparam logic [CountWidth-1:0] TxCountReset    = 4'd8;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_OWN_ADDRESS = 2'd0,
      CSR_TX_DATA     = 2'd1,
      CSR_TX_COUNT    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_ADDR     = 3'd1,
      PH_ACK_WAIT = 3'd2,
      PH_ACK_HOLD = 3'd3,
      PH_TX       = 3'd4,
      PH_MACK     = 3'd5,
      PH_NEXT     = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_READ     = 3'd1,
      EV_WRITE    = 3'd2,
      EV_MISMATCH = 3'd3,
      EV_ACKED    = 3'd4,
      EV_NACK     = 3'd5
   } event_type;

   typedef struct packed {
      logic [AddrWidth-1:0]  own_address;
      logic [DataWidth-1:0]  tx_data;
      logic [CountWidth-1:0] tx_count;
   } cfg_type;

   typedef struct packed {
      event_type event_res;
      logic      busy_res;
      logic      sda_pull_low;
   } result_type;

   // Byte 0 sits in the top byte of the transmit word.
   function automatic logic [7:0] tx_byte(input logic [DataWidth-1:0] data,
                                          input logic [2:0] pos);
      logic [2:0] lane;
      lane = 3'd7 - pos;
      return data[{lane, 3'b000} +: 8];
   endfunction

   // Counts of zero and above eight are clamped into the legal range.
   function automatic logic [CountWidth-1:0] eff_count(input logic [CountWidth-1:0] cnt);
      logic [CountWidth-1:0] res;
      if (cnt == '0) begin
         res = CountWidth'(1);
      end else if (cnt > CountWidth'(MaxBytes)) begin
         res = CountWidth'(MaxBytes);
      end else begin
         res = cnt;
      end
      return res;
   endfunction

endpackage

FILE: rtl/i2ct_csr.sv
// Configuration registers of the I2C target, written through a plain write port.
`timescale 1ns / 1ps

module i2ct_csr import i2ct_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_addr,
   input  logic [DataWidth-1:0]   csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_OWN_ADDRESS: cfg_in.own_address = csr_wdata[AddrWidth-1:0];
            CSR_TX_DATA:     cfg_in.tx_data     = csr_wdata;
            CSR_TX_COUNT:    cfg_in.tx_count    = csr_wdata[CountWidth-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address <= OwnAddressReset;
         cfg_ff.tx_data     <= TxDataReset;
         cfg_ff.tx_count    <= TxCountReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/i2ct_step.sv
// Bus state tracking of the I2C target: one line sample per item in, one result out.
`timescale 1ns / 1ps

module i2ct_step import i2ct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       scl,
   input  logic       sda,
   input  cfg_type    cfg,
   output result_type result
);

   logic       scl_prev_ff, scl_prev_in;
   logic       sda_prev_ff, sda_prev_in;
   phase_type  phase_ff, phase_in;
   logic [3:0] bit_cnt_ff, bit_cnt_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] byte_pos_ff, byte_pos_in;
   logic       drive_low_ff, drive_low_in;
   event_type  event_in;

   logic       rising, falling, held_high, start_cond, stop_cond;
   logic [3:0] bit_cnt_inc;
   logic [3:0] byte_pos_inc;
   logic [7:0] addr_shift;
   logic [7:0] load_value;

   assign rising       = !scl_prev_ff && scl;
   assign falling      = scl_prev_ff && !scl;
   assign held_high    = scl_prev_ff && scl;
   assign start_cond   = held_high && sda_prev_ff && !sda;
   assign stop_cond    = held_high && !sda_prev_ff && sda;
   assign bit_cnt_inc  = bit_cnt_ff + 4'd1;
   assign byte_pos_inc = byte_pos_ff + 4'd1;
   assign addr_shift   = {shift_ff[6:0], sda};

   // The first load after the address acknowledge always starts from byte zero.
   assign load_value = tx_byte(cfg.tx_data,
                               (phase_ff == PH_ACK_HOLD) ? 3'd0 : byte_pos_ff[2:0]);

   always_comb begin
      phase_in     = phase_ff;
      bit_cnt_in   = bit_cnt_ff;
      shift_in     = shift_ff;
      byte_pos_in  = byte_pos_ff;
      drive_low_in = drive_low_ff;
      event_in     = EV_NONE;
      scl_prev_in  = scl;
      sda_prev_in  = sda;
      if (start_cond) begin
         phase_in     = PH_ADDR;
         bit_cnt_in   = '0;
         shift_in     = '0;
         byte_pos_in  = '0;
         drive_low_in = 1'b0;
      end else if (stop_cond) begin
         phase_in     = PH_IDLE;
         bit_cnt_in   = '0;
         drive_low_in = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_ADDR: begin
               if (rising) begin
                  shift_in   = addr_shift;
                  bit_cnt_in = bit_cnt_inc;
                  if (bit_cnt_inc >= 4'd8) begin
                     bit_cnt_in = '0;
                     if (addr_shift[7:1] == cfg.own_address) begin
                        event_in = addr_shift[0] ? EV_READ : EV_WRITE;
                        phase_in = PH_ACK_WAIT;
                     end else begin
                        event_in = EV_MISMATCH;
                        phase_in = PH_IDLE;
                     end
                  end
               end
            end
            PH_ACK_WAIT: begin
               if (falling) begin
                  drive_low_in = 1'b1;
                  phase_in     = PH_ACK_HOLD;
               end
            end
            PH_ACK_HOLD: begin
               if (falling) begin
                  if (shift_ff[0]) begin
                     byte_pos_in  = '0;
                     shift_in     = load_value;
                     bit_cnt_in   = '0;
                     drive_low_in = !load_value[7];
                     phase_in     = PH_TX;
                  end else begin
                     drive_low_in = 1'b0;
                     phase_in     = PH_IDLE;
                  end
               end
            end
            PH_TX: begin
               if (rising) begin
                  bit_cnt_in = bit_cnt_inc;
               end else if (falling) begin
                  if (bit_cnt_ff >= 4'd8) begin
                     bit_cnt_in   = '0;
                     drive_low_in = 1'b0;
                     phase_in     = PH_MACK;
                  end else begin
                     shift_in     = {shift_ff[6:0], 1'b0};
                     drive_low_in = !shift_ff[6];
                  end
               end
            end
            PH_MACK: begin
               if (rising) begin
                  if (sda) begin
                     event_in = EV_NACK;
                     phase_in = PH_IDLE;
                  end else begin
                     event_in    = EV_ACKED;
                     byte_pos_in = byte_pos_inc;
                     phase_in    = (byte_pos_inc >= eff_count(cfg.tx_count)) ? PH_IDLE : PH_NEXT;
                  end
               end
            end
            PH_NEXT: begin
               if (falling) begin
                  shift_in     = load_value;
                  bit_cnt_in   = '0;
                  drive_low_in = !load_value[7];
                  phase_in     = PH_TX;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      result.sda_pull_low = drive_low_in;
      result.busy_res     = (phase_in != PH_IDLE);
      result.event_res    = event_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_prev_ff  <= 1'b1;
         sda_prev_ff  <= 1'b1;
         phase_ff     <= PH_IDLE;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         byte_pos_ff  <= '0;
         drive_low_ff <= 1'b0;
      end else if (step_en) begin
         scl_prev_ff  <= scl_prev_in;
         sda_prev_ff  <= sda_prev_in;
         phase_ff     <= phase_in;
         bit_cnt_ff   <= bit_cnt_in;
         shift_ff     <= shift_in;
         byte_pos_ff  <= byte_pos_in;
         drive_low_ff <= drive_low_in;
      end
   end

   // The data line is only driven during the address acknowledge and while sending.
   assert property (@(posedge clock) disable iff (reset)
      drive_low_ff |-> (phase_ff == PH_ACK_HOLD || phase_ff == PH_TX))
      else $error("data line driven outside acknowledge or transmit");

   assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff <= 4'd8)
      else $error("bit counter ran past eight");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ADDR) |-> (bit_cnt_ff < 4'd8))
      else $error("address phase kept after the eighth bit");

endmodule

FILE: rtl/i2ct_skid.sv
// Result register with a skid stage so that the step logic runs while a result waits.
`timescale 1ns / 1ps

module i2ct_skid import i2ct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       take;

   assign take = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_data_in = push_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full       = skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds an item ahead of the output register");

   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("skid item dropped while the output was stalled");

endmodule

FILE: rtl/i2c_target_address_ack_and_read_top.sv
// Top level of the I2C target: input register, step logic, result skid and registers.
//
//  Channel | Direction | Payload
//  req_    | in        | tdata[0] scl_level, tdata[1] sda_level
//  rsp_    | out       | tdata[0] sda_pull_low, tdata[1] busy_res, tdata[4:2] event_res
//  csr_    | in        | write enable, register index, 64-bit write data
//
// An item is registered in the input register on acceptance; its result goes from the step logic
// into the output register, or into the skid stage while the output register is still waiting.
// One item is accepted in every cycle unless a sample is held and the skid stage is full.
// Reset is synchronous; afterwards the bus is assumed idle with both lines high.
// A stalled result is parked in a skid stage; input stops only once that stage is full.
`timescale 1ns / 1ps

module i2c_target_address_ack_and_read_top import i2ct_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [0] scl_level, [1] sda_level
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [0] sda_pull_low, [1] busy_res, [4:2] event_res
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_addr,
   input  logic [DataWidth-1:0]   csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   logic       scl_ff, sda_ff;
   logic       advance;
   logic       skid_full;
   cfg_type    cfg;
   result_type step_result;
   result_type rsp_data;

   i2ct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The held sample is processed as soon as the result side has room for it.
   assign advance     = in_valid_ff && !skid_full;
   assign req_tready  = !in_valid_ff || !skid_full;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         scl_ff <= req_tdata[0];
         sda_ff <= req_tdata[1];
      end
   end

   i2ct_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .scl     (scl_ff),
      .sda     (sda_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   i2ct_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (advance),
      .push_data  (step_result),
      .full       (skid_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {3'b000, rsp_data.event_res, rsp_data.busy_res, rsp_data.sda_pull_low};

endmodule
